[src/svf_pkg.sv]
// Shared types, widths and reset constants for the state variable filter.
package svf_pkg;

  localparam int IW             = 32;
  localparam int CW             = 32;
  localparam int EXTRA_BITS     = 8;
  localparam int SAMPLE_W_DEF   = 24;
  localparam int COEF_FRAC_DEF  = 30;

  localparam int A_W            = 31;
  localparam int K_W            = 32;
  localparam int MODE_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [A_W-1:0]    A1_RST   = 31'd945713144;
  localparam logic [A_W-1:0]    A2_RST   = 31'd61984968;
  localparam logic [A_W-1:0]    A3_RST   = 31'd4062666;
  localparam logic [K_W-1:0]    K_RST    = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A1   = 3'd0,
    CFG_A2   = 3'd1,
    CFG_A3   = 3'd2,
    CFG_K    = 3'd3,
    CFG_MODE = 3'd4
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOW     = 3'd0,
    MODE_HIGH    = 3'd1,
    MODE_BAND    = 3'd2,
    MODE_NOTCH   = 3'd3,
    MODE_PEAK    = 3'd4,
    MODE_ALLPASS = 3'd5
  } mode_e;

  localparam logic [MODE_W-1:0] MODE_RST = MODE_LOW;

  typedef enum logic [1:0] {
    RND_1 = 2'd0,
    RND_2 = 2'd1,
    RND_3 = 2'd2
  } rnd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN1,
    ST_WAIT1,
    ST_RUN2,
    ST_WAIT2,
    ST_UPD,
    ST_WAIT3,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic ld_in;
    logic mul_start;
    rnd_e rnd;
    logic ld_v1;
    logic ld_v2;
    logic upd;
    logic ld_high;
    logic ld_out;
  } svf_ctl_t;

endpackage

[src/svf_smul.sv]
// Bit-serial shift-add multiplier: unsigned coefficient times signed value, rounded.
module svf_smul import svf_pkg::*; #(
  parameter int  FRAC = COEF_FRAC_DEF,
  localparam int PW   = IW + CW - FRAC + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CW-1:0]        coef_i,
  input  logic signed [IW-1:0] x_i,
  output logic                 done_o,
  output logic signed [PW-1:0] prod_o
);

  localparam int CNT_W = $clog2(CW + 1);

  logic                 busy_q;
  logic                 fin_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IW-1:0]        m_q;
  logic [IW-1:0]        hi_q;
  logic [CW-1:0]        c_q;
  logic [CW-1:0]        lo_q;
  logic                 neg_q;
  logic signed [PW-1:0] prod_q;
  logic [IW:0]          sum;
  logic [IW+CW-1:0]     p;
  logic signed [PW-1:0] mag;

  assign sum = {1'b0, hi_q} + (c_q[0] ? {1'b0, m_q} : '0);
  assign p   = {hi_q, lo_q};
  // round half away from zero on the magnitude
  assign mag = PW'(p[IW+CW-1:FRAC]) + PW'(p[FRAC-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(CW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q   <= x_i[IW-1] ? IW'(-x_i) : IW'(x_i);
      neg_q <= x_i[IW-1];
      c_q   <= coef_i;
      hi_q  <= '0;
      lo_q  <= '0;
    end else if (busy_q) begin
      hi_q <= sum[IW:1];
      lo_q <= {sum[0], lo_q[CW-1:1]};
      c_q  <= c_q >> 1;
    end
    if (fin_q) begin
      prod_q <= neg_q ? -mag : mag;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

[src/svf_dp.sv]
// Filter datapath: integrators, intermediate values, two serial multipliers, output stage.
module svf_dp import svf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  svf_ctl_t                      ctl_i,
  input  logic [A_W-1:0]                a1_i,
  input  logic [A_W-1:0]                a2_i,
  input  logic [A_W-1:0]                a3_i,
  input  logic [K_W-1:0]                k_i,
  input  logic [MODE_W-1:0]             mode_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                          mul_done_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int VW  = SW + EXTRA_BITS;
  localparam int PW  = IW + CW - COEF_FRAC_BITS + 1;
  localparam int MW1 = (VW > PW) ? VW : PW;
  localparam int MW2 = (MW1 > IW) ? MW1 : IW;
  localparam int AW  = MW2 + 3;

  localparam logic signed [AW-1:0] IW_MAX = {{(AW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [AW-1:0] IW_MIN = ~IW_MAX;
  localparam logic signed [AW-1:0] SW_MAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] SW_MIN = ~SW_MAX;
  localparam logic signed [AW-1:0] HALF   = {{(AW-EXTRA_BITS+1){1'b0}},
                                             {(EXTRA_BITS-1){1'b0}}} | (AW'(1) << (EXTRA_BITS-1));

  function automatic logic signed [IW-1:0] sat_iw(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] r;
    r = x;
    if (x > IW_MAX) r = IW_MAX;
    if (x < IW_MIN) r = IW_MIN;
    return r[IW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] r;
    r = x;
    if (x > SW_MAX) r = SW_MAX;
    if (x < SW_MIN) r = SW_MIN;
    return r[SW-1:0];
  endfunction

  logic signed [VW-1:0] v0_in;
  logic signed [VW-1:0] v0_q;
  logic signed [IW-1:0] v3_q;
  logic signed [IW-1:0] v1_q;
  logic signed [IW-1:0] v2_q;
  logic signed [IW-1:0] ic1_q;
  logic signed [IW-1:0] ic2_q;
  logic signed [PW-1:0] kb_q;
  logic signed [AW-1:0] high_q;
  logic signed [SW-1:0] out_q;

  logic [CW-1:0]        coef_a;
  logic [CW-1:0]        coef_b;
  logic signed [IW-1:0] x_a;
  logic signed [IW-1:0] x_b;
  logic                 done_a;
  logic                 done_b;
  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic signed [AW-1:0] res;
  logic signed [AW-1:0] res_rnd;

  assign v0_in = {sample_in_i, {EXTRA_BITS{1'b0}}};

  always_comb begin
    case (ctl_i.rnd)
      RND_1: begin
        coef_a = CW'(a1_i);
        x_a    = ic1_q;
        coef_b = CW'(a2_i);
        x_b    = v3_q;
      end
      RND_2: begin
        coef_a = CW'(a2_i);
        x_a    = ic1_q;
        coef_b = CW'(a3_i);
        x_b    = v3_q;
      end
      default: begin
        coef_a = CW'(k_i);
        x_a    = v1_q;
        coef_b = CW'(a3_i);
        x_b    = v3_q;
      end
    endcase
  end

  svf_smul #(.FRAC(COEF_FRAC_BITS)) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.mul_start),
    .coef_i  (coef_a),
    .x_i     (x_a),
    .done_o  (done_a),
    .prod_o  (prod_a)
  );

  svf_smul #(.FRAC(COEF_FRAC_BITS)) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.mul_start),
    .coef_i  (coef_b),
    .x_i     (x_b),
    .done_o  (done_b),
    .prod_o  (prod_b)
  );

  assign mul_done_o = done_a & done_b;

  always_comb begin
    case (mode_i)
      MODE_HIGH:    res = high_q;
      MODE_BAND:    res = AW'(v1_q);
      MODE_NOTCH:   res = AW'(v2_q) + high_q;
      MODE_PEAK:    res = AW'(v2_q) - high_q;
      MODE_ALLPASS: res = AW'(v0_q) - (AW'(kb_q) <<< 1);
      default:      res = AW'(v2_q);
    endcase
  end

  // round to nearest, ties toward plus infinity
  assign res_rnd = (res + HALF) >>> EXTRA_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic1_q <= '0;
      ic2_q <= '0;
    end else if (ctl_i.upd) begin
      ic1_q <= sat_iw((AW'(v1_q) <<< 1) - AW'(ic1_q));
      ic2_q <= sat_iw((AW'(v2_q) <<< 1) - AW'(ic2_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      v0_q <= v0_in;
      v3_q <= sat_iw(AW'(v0_in) - AW'(ic2_q));
    end
    if (ctl_i.ld_v1) begin
      v1_q <= sat_iw(AW'(prod_a) + AW'(prod_b));
    end
    if (ctl_i.ld_v2) begin
      v2_q <= sat_iw(AW'(ic2_q) + AW'(prod_a) + AW'(prod_b));
    end
    if (ctl_i.ld_high) begin
      kb_q   <= prod_a;
      high_q <= AW'(v0_q) - AW'(prod_a) - AW'(v2_q);
    end
    if (ctl_i.ld_out) begin
      out_q <= sat_sw(res_rnd);
    end
  end

  assign sample_out_o = out_q;

endmodule

[src/svf_ctrl.sv]
// Sequencer for the multiply rounds and the input and output handshakes.
module svf_ctrl import svf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_stall_i,
  input  logic     mul_done_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output svf_ctl_t ctl_o
);

  st_e  state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.rnd = RND_1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.ld_in = 1'b1;
          state_d     = ST_RUN1;
        end
      end
      ST_RUN1: begin
        ctl_o.mul_start = 1'b1;
        ctl_o.rnd       = RND_1;
        state_d         = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (mul_done_i) begin
          ctl_o.ld_v1 = 1'b1;
          state_d     = ST_RUN2;
        end
      end
      ST_RUN2: begin
        ctl_o.mul_start = 1'b1;
        ctl_o.rnd       = RND_2;
        state_d         = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (mul_done_i) begin
          ctl_o.ld_v2 = 1'b1;
          state_d     = ST_UPD;
        end
      end
      ST_UPD: begin
        ctl_o.mul_start = 1'b1;
        ctl_o.rnd       = RND_3;
        ctl_o.upd       = 1'b1;
        state_d         = ST_WAIT3;
      end
      ST_WAIT3: begin
        if (mul_done_i) begin
          ctl_o.ld_high = 1'b1;
          state_d       = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[src/state_variable_filter.sv]
// Top level of the trapezoidal state variable filter.
// One signed sample per transaction, one filtered sample back. The filter takes no new
// sample until the last one has reached the output register: it runs three rounds of
// bit-serial multiplication (one coefficient bit per cycle over 32 bits, plus load and
// rounding), two multipliers working side by side in every round. A finished result
// sits in an output register, so the next sample is taken while it waits. The user must
// write coefficients, damping and mode through the configuration port only while the
// filter is idle; the block itself does not enforce it.
module state_variable_filter import svf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  logic [A_W-1:0]    a1_q;
  logic [A_W-1:0]    a2_q;
  logic [A_W-1:0]    a3_q;
  logic [K_W-1:0]    k_q;
  logic [MODE_W-1:0] mode_q;
  svf_ctl_t          ctl;
  logic              mul_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q   <= A1_RST;
      a2_q   <= A2_RST;
      a3_q   <= A3_RST;
      k_q    <= K_RST;
      mode_q <= MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_A1:   a1_q   <= cfg_data_i[A_W-1:0];
        CFG_A2:   a2_q   <= cfg_data_i[A_W-1:0];
        CFG_A3:   a3_q   <= cfg_data_i[A_W-1:0];
        CFG_K:    k_q    <= cfg_data_i[K_W-1:0];
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  svf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .mul_done_i  (mul_done),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  svf_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .a1_i         (a1_q),
    .a2_i         (a2_q),
    .a3_i         (a3_q),
    .k_i          (k_q),
    .mode_i       (mode_q),
    .sample_in_i  (sample_in_i),
    .mul_done_o   (mul_done),
    .sample_out_o (sample_out_o)
  );

endmodule

[src/svf_chk.sv]
// Port-level checker for the state variable filter, bound to the top level.
module svf_chk import svf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken again right after a transaction");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while the input side is still busy");

  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 2'd2) && (!out_valid_o || (pend_q != 2'd0)))
    else $error("result count does not track accepted transactions");

endmodule

bind state_variable_filter svf_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_svf_chk (.*);

[test/state_variable_filter_tb.sv]
// Self-checking testbench for state_variable_filter: bit-exact predictor, random traffic and stalls.
`timescale 1ns / 100ps

module state_variable_filter_tb import svf_pkg::*; ();

  localparam int SW = SAMPLE_W_DEF;
  localparam int REPORT_LIMIT = 10;
  localparam int CFG_COUNT = 5;
  localparam int RANDOM_ITEMS = 1880;
  localparam logic [CFG_DATA_W-1:0] K_MIN = 32'd107374;
  localparam logic [CFG_DATA_W-1:0] Q30_ONE = 32'h4000_0000;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam real PI = 3.14159265358979;
  localparam real Q30_SCALE = 1073741824.0;

  class svf_sample_board;
    logic [A_W-1:0] a1, a2, a3;
    logic [K_W-1:0] k;
    logic [MODE_W-1:0] mode;
    longint integ1, integ2;
    logic signed [SW-1:0] expected_samples[$];
    int mismatch_count;
    int out_index;

    function new();
      a1 = A1_RST;
      a2 = A2_RST;
      a3 = A3_RST;
      k = K_RST;
      mode = MODE_RST;
      integ1 = 0;
      integ2 = 0;
      mismatch_count = 0;
      out_index = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_A1:   a1 = data[A_W-1:0];
        CFG_A2:   a2 = data[A_W-1:0];
        CFG_A3:   a3 = data[A_W-1:0];
        CFG_K:    k = data[K_W-1:0];
        CFG_MODE: mode = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint x, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    // |x| * c rounded half away from zero, sign restored
    function longint coef_product(logic [31:0] c, longint x);
      logic [63:0] mag, prod;
      mag = (x < 0) ? -x : x;
      prod = (mag * {32'd0, c} + (64'd1 << (COEF_FRAC_DEF - 1))) >> COEF_FRAC_DEF;
      return (x < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function void take_sample(logic signed [SW-1:0] s);
      longint v0, v3, v1, v2, kb, high, res;
      logic signed [SW-1:0] out_sample;
      v0 = longint'(s) <<< EXTRA_BITS;
      v3 = clamp(v0 - integ2, IW);
      v1 = clamp(coef_product(CW'(a1), integ1) + coef_product(CW'(a2), v3), IW);
      v2 = clamp(integ2 + coef_product(CW'(a2), integ1) + coef_product(CW'(a3), v3), IW);
      integ1 = clamp(2 * v1 - integ1, IW);
      integ2 = clamp(2 * v2 - integ2, IW);
      kb = coef_product(k, v1);
      high = v0 - kb - v2;
      case (mode)
        MODE_HIGH:    res = high;
        MODE_BAND:    res = v1;
        MODE_NOTCH:   res = v2 + high;
        MODE_PEAK:    res = v2 - high;
        MODE_ALLPASS: res = v0 - 2 * kb;
        default:      res = v2;
      endcase
      res = (res + (longint'(1) <<< (EXTRA_BITS - 1))) >>> EXTRA_BITS;
      res = clamp(res, SW);
      out_sample = res[SW-1:0];
      expected_samples.push_back(out_sample);
    endfunction

    function void compare_output(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: output %0d with no sample pending, got %0d", $time, out_index, got);
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: output %0d expected %0d, got %0d", $time, out_index, want, got);
        end
      end
      out_index++;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [SW-1:0]    sample_in_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [SW-1:0]    sample_out_o;

  svf_sample_board board;
  int unsigned burst_left = 0;
  logic signed [SW-1:0] last_sample = '0;

  state_variable_filter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.compare_output(sample_out_o);
    end
  end

  // Output back-pressure: stretches of no stall, sparse, even, heavy and solid stall
  initial begin
    int unsigned kind, span;
    forever begin
      kind = $urandom_range(0, 4);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk_i);
        case (kind)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= 1'($urandom_range(0, 1));
          3: out_stall_i <= ($urandom_range(0, 7) != 0);
          default: out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input logic signed [SW-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(s);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    board.load_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic program_filter(input logic [CFG_DATA_W-1:0] a1, a2, a3, k, mode_word,
                                input bit stray);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_A3, a3);
    write_reg(CFG_K, k);
    write_reg(CFG_MODE, mode_word);
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_COUNT, (1 << CFG_IDX_W) - 1)), $urandom());
    end
    cfg_we_i <= 1'b0;
  endtask

  // Coefficients of a real filter: random cutoff up to near Nyquist, random damping
  task automatic tuned_setting(output logic [CFG_DATA_W-1:0] a1, a2, a3, k);
    real g, kr, c1, c2, c3;
    g = $tan(PI * ($urandom_range(1, 4900) / 10000.0));
    kr = $urandom_range(1, 20000) / 10000.0;
    c1 = 1.0 / (1.0 + g * (g + kr));
    c2 = g * c1;
    c3 = g * c2;
    a1 = CFG_DATA_W'(longint'(c1 * Q30_SCALE));
    a2 = CFG_DATA_W'(longint'(c2 * Q30_SCALE));
    a3 = CFG_DATA_W'(longint'(c3 * Q30_SCALE));
    k = CFG_DATA_W'(longint'(kr * Q30_SCALE));
  endtask

  function automatic logic [CFG_DATA_W-1:0] extreme_coef();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return Q30_ONE;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(0, Q30_ONE);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] extreme_damping();
    case ($urandom_range(0, 4))
      0: return K_MIN;
      1: return K_RST;
      2: return '1;
      3: return $urandom();
      default: return $urandom_range(K_MIN, K_RST);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] next_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: last_sample = SW'($urandom());
      4, 5: last_sample = SW'(int'($urandom_range(0, 2000)) - 1000);
      6: last_sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      7: last_sample = SW'(int'($urandom_range(0, 4)) - 2);
      default: ; // hold the previous level: step response
    endcase
    return last_sample;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] a1, a2, a3, k, mode_word;
    int unsigned sent, n;
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset coefficients, low pass
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('1);
    send_sample(SW'(1));
    send_sample('0);

    // every mode but low pass, spare codes included, some with boundary settings
    for (int m = MODE_HIGH; m < (1 << MODE_W); m++) begin
      settle();
      case (m)
        MODE_HIGH:    program_filter(CFG_DATA_W'(A1_RST), CFG_DATA_W'(A2_RST),
                                     CFG_DATA_W'(A3_RST), K_MIN, m, 1'b0);
        MODE_BAND:    program_filter(Q30_ONE, Q30_ONE, Q30_ONE, K_RST, m, 1'b0);
        MODE_NOTCH:   program_filter('0, '0, '0, K_MIN, m, 1'b0);
        MODE_ALLPASS: program_filter('1, '1, '1, '1, m, 1'b0);
        default:      program_filter(CFG_DATA_W'(A1_RST), CFG_DATA_W'(A2_RST),
                                     CFG_DATA_W'(A3_RST), K_RST, m, m > MODE_ALLPASS);
      endcase
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 9) < 6) begin
        tuned_setting(a1, a2, a3, k);
      end else begin
        a1 = extreme_coef();
        a2 = extreme_coef();
        a3 = extreme_coef();
        k = extreme_damping();
      end
      mode_word = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, MODE_ALLPASS);
      program_filter(a1, a2, a3, k, mode_word, $urandom_range(0, 7) == 0);
      n = $urandom_range(5, 80);
      repeat (n) send_sample(next_sample());
      sent += n;
    end

    settle();
    repeat (150) @(negedge clk_i);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
